// File: rtl/core/two_link_arm_inverse_kinematics_macros.svh
// Assertion macros for the two-link arm inverse kinematics block.
// Taken in by the checker file; no other dependencies.
`ifndef TWO_LINK_ARM_INVERSE_KINEMATICS_MACROS_SVH
`define TWO_LINK_ARM_INVERSE_KINEMATICS_MACROS_SVH

// Clocked property, switched off while reset is high.
`define IKIN_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Condition that must never be seen.
`define IKIN_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `IKIN_ASSERT(label, clk, rst, !(cond), msg)

`endif

// File: rtl/core/ikin_pkg.sv
// Shared constants, types and tables of the arm inverse kinematics block.
// No dependencies; every other file but the macro header refers to it by scoped names.
`default_nettype none

package ikin_pkg;

   localparam int FRACTION_BITS = 4;
   localparam int CORDIC_STAGES = 16;
   localparam int SQRT_GUARD    = 14;
   localparam int PRESCALE      = 20;

   // chain lengths
   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 20;

   // datapath widths
   localparam int SQW = 64;  // square root remainder and root
   localparam int PW  = 54;  // product of a delta and a root
   localparam int DVW = 56;  // numerator magnitude and divider remainder
   localparam int CW  = 44;  // CORDIC x and y
   localparam int ZW  = 27;  // CORDIC angle in 2^-16 degree
   localparam int SHW = 5;   // shift count inside a cell

   localparam logic [15:0]          LINK_RESET  = 16'(30 << FRACTION_BITS);
   localparam logic [SQW-1:0]       SQ_TOP_BIT  = SQW'(1) << (SQW - 2);
   localparam logic [14:0]          ANGLE_UP    = 15'd5760;
   localparam logic [14:0]          ANGLE_DOWN  = 15'd17280;
   localparam logic [14:0]          FULL_TURN   = 15'd23040;
   localparam logic signed [ZW-1:0] HALF_TURN_Z = ZW'(180 * 65536);
   localparam logic signed [ZW-1:0] ROUND_Z     = ZW'(512);
   localparam int                   ROUND_SHIFT = 10;

   // arctangent of 2^-i in 2^-16 degree
   localparam logic [22:0] ATAN_TAB [32] = '{
      23'd2949120, 23'd1740967, 23'd919879, 23'd466945,
      23'd234379,  23'd117304,  23'd58666,  23'd29335,
      23'd14668,   23'd7334,    23'd3667,   23'd1833,
      23'd917,     23'd458,     23'd229,    23'd115,
      23'd57,      23'd29,      23'd14,     23'd7,
      23'd4,       23'd2,       23'd1,      23'd0,
      23'd0,       23'd0,       23'd0,      23'd0,
      23'd0,       23'd0,       23'd0,      23'd0
   };

   typedef logic signed [19:0] coord_type;
   typedef logic signed [20:0] delta_type;
   typedef logic [14:0]        angle_type;

   // travels beside the square root chain
   typedef struct packed {
      logic      oor;
      logic      side;
      coord_type ax;
      coord_type ay;
      delta_type dx;
      delta_type dy;
   } sq_sb_type;

   // travels beside the divider chain
   typedef struct packed {
      logic        oor;
      coord_type   ax;
      coord_type   ay;
      delta_type   dx;
      delta_type   dy;
      logic        xneg;
      logic        yneg;
      logic [32:0] divisor;
   } dv_sb_type;

   // travels beside the CORDIC chain
   typedef struct packed {
      logic      oor;
      coord_type jx;
      coord_type jy;
      logic      fix1;
      angle_type fixv1;
      logic      fix2;
      angle_type fixv2;
   } cr_sb_type;

   // CORDIC start values of one vector
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 fix;
      angle_type            fixv;
   } cr_init_type;

   // one result word
   typedef struct packed {
      coord_type joint_x;
      coord_type joint_y;
      angle_type first_angle;
      angle_type second_angle;
      logic      out_of_reach;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: rtl/core/ikin_ifs.sv
// Channel interfaces of the arm inverse kinematics block: query, result, link length.
// Depends on ikin_pkg for field types.
`default_nettype none

interface ikin_req_if;
   logic                  valid;
   logic                  ready;
   ikin_pkg::coord_type   target_x;
   ikin_pkg::coord_type   target_y;
   ikin_pkg::coord_type   anchor_x;
   ikin_pkg::coord_type   anchor_y;
   logic                  elbow_side;

   modport source (output valid, target_x, target_y, anchor_x, anchor_y, elbow_side,
                   input ready);
   modport sink   (input valid, target_x, target_y, anchor_x, anchor_y, elbow_side,
                   output ready);
endinterface

interface ikin_rsp_if;
   logic                  valid;
   logic                  ready;
   ikin_pkg::coord_type   joint_x;
   ikin_pkg::coord_type   joint_y;
   ikin_pkg::angle_type   first_angle;
   ikin_pkg::angle_type   second_angle;
   logic                  out_of_reach;

   modport source (output valid, joint_x, joint_y, first_angle, second_angle, out_of_reach,
                   input ready);
   modport sink   (input valid, joint_x, joint_y, first_angle, second_angle, out_of_reach,
                   output ready);
endinterface

interface ikin_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] link_length;

   modport source (output valid, link_length, input ready);
   modport sink   (input valid, link_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ikin_sqrt_cell.sv
// One bit step of the integer square root chain (one result bit, two bits of radicand per cell).
// Depends on ikin_pkg for widths.
`default_nettype none

module ikin_sqrt_cell (
   input  wire logic                     clock,
   input  wire logic                     advance,
   input  wire logic [ikin_pkg::SQW-1:0] step_bit,
   input  wire logic [ikin_pkg::SQW-1:0] num_in,
   input  wire logic [ikin_pkg::SQW-1:0] root_in,
   output logic      [ikin_pkg::SQW-1:0] num_out,
   output logic      [ikin_pkg::SQW-1:0] root_out
);

   logic [ikin_pkg::SQW-1:0] trial;
   logic                     take;
   logic [ikin_pkg::SQW-1:0] num_in_d;
   logic [ikin_pkg::SQW-1:0] root_in_d;
   logic [ikin_pkg::SQW-1:0] num_ff;
   logic [ikin_pkg::SQW-1:0] root_ff;

   // subtract the trial square when it fits
   always_comb begin
      trial     = root_in + step_bit;
      take      = (num_in >= trial);
      num_in_d  = take ? (num_in - trial) : num_in;
      root_in_d = take ? ((root_in >> 1) + step_bit) : (root_in >> 1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff  <= num_in_d;
         root_ff <= root_in_d;
      end
   end

   assign num_out  = num_ff;
   assign root_out = root_ff;

endmodule

`default_nettype wire

// File: rtl/core/ikin_div_cell.sv
// One quotient bit of the restoring divider chain.
// Depends on ikin_pkg for widths.
`default_nettype none

module ikin_div_cell (
   input  wire logic [ikin_pkg::SHW-1:0]  shift,
   input  wire logic                      clock,
   input  wire logic                      advance,
   input  wire logic [32:0]               divisor,
   input  wire logic [ikin_pkg::DVW-1:0]  rem_in,
   input  wire logic [ikin_pkg::DIV_STEPS-1:0] quot_in,
   output logic      [ikin_pkg::DVW-1:0]  rem_out,
   output logic      [ikin_pkg::DIV_STEPS-1:0] quot_out
);

   logic [ikin_pkg::DVW-1:0]       trial;
   logic                           take;
   logic [ikin_pkg::DVW-1:0]       rem_in_d;
   logic [ikin_pkg::DIV_STEPS-1:0] quot_in_d;
   logic [ikin_pkg::DVW-1:0]       rem_ff;
   logic [ikin_pkg::DIV_STEPS-1:0] quot_ff;

   // divisor aligned to this cell's quotient bit
   always_comb begin
      trial     = ikin_pkg::DVW'(divisor) << shift;
      take      = (rem_in >= trial);
      rem_in_d  = take ? (rem_in - trial) : rem_in;
      quot_in_d = {quot_in[ikin_pkg::DIV_STEPS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in_d;
         quot_ff <= quot_in_d;
      end
   end

   assign rem_out  = rem_ff;
   assign quot_out = quot_ff;

endmodule

`default_nettype wire

// File: rtl/core/ikin_cordic_cell.sv
// One vectoring CORDIC rotation; drives y toward zero and sums the angle.
// Depends on ikin_pkg for widths.
`default_nettype none

module ikin_cordic_cell (
   input  wire logic                           clock,
   input  wire logic                           advance,
   input  wire logic [ikin_pkg::SHW-1:0]       shift,
   input  wire logic [22:0]                    atan,
   input  wire logic signed [ikin_pkg::CW-1:0] x_in,
   input  wire logic signed [ikin_pkg::CW-1:0] y_in,
   input  wire logic signed [ikin_pkg::ZW-1:0] z_in,
   output logic      signed [ikin_pkg::CW-1:0] x_out,
   output logic      signed [ikin_pkg::CW-1:0] y_out,
   output logic      signed [ikin_pkg::ZW-1:0] z_out
);

   logic signed [ikin_pkg::CW-1:0] xs;
   logic signed [ikin_pkg::CW-1:0] ys;
   logic signed [ikin_pkg::ZW-1:0] at;
   logic signed [ikin_pkg::CW-1:0] x_in_d;
   logic signed [ikin_pkg::CW-1:0] y_in_d;
   logic signed [ikin_pkg::ZW-1:0] z_in_d;
   logic signed [ikin_pkg::CW-1:0] x_ff;
   logic signed [ikin_pkg::CW-1:0] y_ff;
   logic signed [ikin_pkg::ZW-1:0] z_ff;

   // rotate against the sign of y
   always_comb begin
      xs = x_in >>> shift;
      ys = y_in >>> shift;
      at = signed'(ikin_pkg::ZW'(atan));
      if (y_in > 0) begin
         x_in_d = x_in + ys;
         y_in_d = y_in - xs;
         z_in_d = z_in + at;
      end else begin
         x_in_d = x_in - ys;
         y_in_d = y_in + xs;
         z_in_d = z_in - at;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in_d;
         y_ff <= y_in_d;
         z_ff <= z_in_d;
      end
   end

   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

`default_nettype wire

// File: rtl/core/two_link_arm_inverse_kinematics.sv
// Top level: pipelined inverse kinematics of an equal-length two-link planar arm.
// Depends on ikin_pkg, ikin_ifs and the sqrt, divider and CORDIC cells.
//
//   channel   port       dir   word
//   query     req_chan   in    target, anchor, elbow side
//   result    rsp_chan   out   joint, two link angles, out of reach
//   link      csr_chan   in    link length (always ready)
//
// One word enters per cycle while the skid stage is empty; a query passes through
// 32-cell square root chains, 20-cell divider chains and 16-cell CORDIC chains.
// Reset clears the valid chain, the output stage and sets the link length to 480.
// A stalled result parks in a skid stage; the whole chain then holds until it drains.
`default_nettype none

module two_link_arm_inverse_kinematics (
   input  wire logic  clock,
   input  wire logic  reset,
   ikin_req_if.sink   req_chan,
   ikin_rsp_if.source rsp_chan,
   ikin_csr_if.sink   csr_chan
);

   localparam int SQ_N  = ikin_pkg::SQ_STEPS;
   localparam int DV_N  = ikin_pkg::DIV_STEPS;
   localparam int CR_N  = ikin_pkg::CORDIC_STAGES;
   localparam int LAT   = 5 + SQ_N + 2 + DV_N + 2 + CR_N + 1;
   localparam int SQW   = ikin_pkg::SQW;
   localparam int PW    = ikin_pkg::PW;
   localparam int DVW   = ikin_pkg::DVW;
   localparam int CW    = ikin_pkg::CW;
   localparam int ZW    = ikin_pkg::ZW;

   // saturate a joint coordinate to the field range
   function automatic ikin_pkg::coord_type sat20(input logic signed [21:0] v);
      if (v > 22'sd524287) begin
         sat20 = 20'sd524287;
      end else if (v < -22'sd524288) begin
         sat20 = -20'sd524288;
      end else begin
         sat20 = v[19:0];
      end
   endfunction

   // start values of one angle: quadrant fold, prescale, vertical case
   function automatic ikin_pkg::cr_init_type cordic_prep(input logic signed [21:0] vx,
                                                          input logic signed [21:0] vy);
      ikin_pkg::cr_init_type r;
      logic signed [21:0]    ux;
      logic signed [21:0]    uy;
      r  = '0;
      ux = (vx < 0) ? -vx : vx;
      uy = (vx < 0) ? -vy : vy;
      if (vx == 0) begin
         r.fix  = 1'b1;
         r.fixv = (vy > 0) ? ikin_pkg::ANGLE_UP :
                  ((vy < 0) ? ikin_pkg::ANGLE_DOWN : '0);
      end else begin
         r.x = CW'(ux) <<< ikin_pkg::PRESCALE;
         r.y = CW'(uy) <<< ikin_pkg::PRESCALE;
         r.z = (vx < 0) ? ikin_pkg::HALF_TURN_Z : '0;
      end
      return r;
   endfunction

   // round to 1/64 degree and wrap into one turn
   function automatic ikin_pkg::angle_type angle_done(input logic signed [ZW-1:0] z,
                                                      input logic fix,
                                                      input ikin_pkg::angle_type fixv);
      logic signed [ZW-1:0] zr;
      logic signed [16:0]   rq;
      logic signed [16:0]   rw;
      zr = z + ikin_pkg::ROUND_Z;
      rq = signed'(zr[ZW-1:ikin_pkg::ROUND_SHIFT]);
      rw = (rq < 0) ? (rq + signed'({2'b0, ikin_pkg::FULL_TURN})) : rq;
      angle_done = fix ? fixv : rw[14:0];
   endfunction

   // ---------------------------------------------------------------- control
   logic                       adv;
   logic                       req_fire;
   logic [LAT-1:0]             vld_ff;
   logic [15:0]                link_ff;
   logic                       out_v_ff;
   logic                       skid_v_ff;
   ikin_pkg::rsp_word_type     out_word_ff;
   ikin_pkg::rsp_word_type     skid_word_ff;
   logic                       inc_v;

   assign adv            = !skid_v_ff;
   assign req_chan.ready = adv;
   assign req_fire       = req_chan.valid && adv;
   assign csr_chan.ready = 1'b1;

   // link length register
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= ikin_pkg::LINK_RESET;
      end else if (csr_chan.valid) begin
         link_ff <= csr_chan.link_length;
      end
   end

   // valid bits move with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_fire};
      end
   end

   // ---------------------------------------------------------------- front end
   ikin_pkg::coord_type   p0_tx_ff, p0_ty_ff, p0_ax_ff, p0_ay_ff;
   logic                  p0_side_ff;
   ikin_pkg::sq_sb_type   p1_sb_ff, p2_sb_ff, p3_sb_ff, p4_sb_ff;
   ikin_pkg::sq_sb_type   p1_sb_in;
   logic [40:0]           p2_dx2_ff, p2_dy2_ff;
   logic [31:0]           p2_ll_ff;
   logic signed [41:0]    dx_sq, dy_sq;
   logic [41:0]           p3_d2_ff;
   logic [33:0]           p3_reach2_ff;
   logic [SQW-1:0]        p4_rs_ff, p4_rt_ff;
   logic                  p4_oor_in;
   logic [33:0]           p4_q_in;
   ikin_pkg::sq_sb_type   p4_sb_in;

   always_comb begin
      p1_sb_in      = '0;
      p1_sb_in.side = p0_side_ff;
      p1_sb_in.ax   = p0_ax_ff;
      p1_sb_in.ay   = p0_ay_ff;
      p1_sb_in.dx   = 21'(p0_tx_ff) - 21'(p0_ax_ff);
      p1_sb_in.dy   = 21'(p0_ty_ff) - 21'(p0_ay_ff);
      dx_sq         = 42'(p1_sb_ff.dx) * 42'(p1_sb_ff.dx);
      dy_sq         = 42'(p1_sb_ff.dy) * 42'(p1_sb_ff.dy);
      p4_oor_in     = (p3_d2_ff == '0) || (p3_d2_ff > 42'(p3_reach2_ff));
      p4_q_in       = p3_reach2_ff - p3_d2_ff[33:0];
      p4_sb_in      = p3_sb_ff;
      p4_sb_in.oor  = p4_oor_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // query in
         p0_tx_ff     <= req_chan.target_x;
         p0_ty_ff     <= req_chan.target_y;
         p0_ax_ff     <= req_chan.anchor_x;
         p0_ay_ff     <= req_chan.anchor_y;
         p0_side_ff   <= req_chan.elbow_side;
         // differences
         p1_sb_ff     <= p1_sb_in;
         // squares
         p2_dx2_ff    <= dx_sq[40:0];
         p2_dy2_ff    <= dy_sq[40:0];
         p2_ll_ff     <= 32'(link_ff) * 32'(link_ff);
         p2_sb_ff     <= p1_sb_ff;
         // distance squared and reach squared
         p3_d2_ff     <= 42'(p2_dx2_ff) + 42'(p2_dy2_ff);
         p3_reach2_ff <= {p2_ll_ff, 2'b00};
         p3_sb_ff     <= p2_sb_ff;
         // reach test, radicands with guard bits
         p4_rs_ff     <= p4_oor_in ? '0 :
                         {2'b00, p4_q_in, (2 * ikin_pkg::SQRT_GUARD)'(0)};
         p4_rt_ff     <= p4_oor_in ? '0 :
                         {2'b00, p3_d2_ff[33:0], (2 * ikin_pkg::SQRT_GUARD)'(0)};
         p4_sb_ff     <= p4_sb_in;
      end
   end

   // ---------------------------------------------------------------- square roots
   logic [SQW-1:0]      s_num_w [SQ_N];
   logic [SQW-1:0]      s_root_w [SQ_N];
   logic [SQW-1:0]      t_num_w [SQ_N];
   logic [SQW-1:0]      t_root_w [SQ_N];
   ikin_pkg::sq_sb_type sq_sb_ff [SQ_N];

   for (genvar k = 0; k < SQ_N; k++) begin : g_sq
      logic [SQW-1:0] s_num_i, s_root_i, t_num_i, t_root_i;
      if (k == 0) begin : g_head
         assign s_num_i  = p4_rs_ff;
         assign s_root_i = '0;
         assign t_num_i  = p4_rt_ff;
         assign t_root_i = '0;
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_sb_ff[k] <= p4_sb_ff;
            end
         end
      end else begin : g_link
         assign s_num_i  = s_num_w[k-1];
         assign s_root_i = s_root_w[k-1];
         assign t_num_i  = t_num_w[k-1];
         assign t_root_i = t_root_w[k-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               sq_sb_ff[k] <= sq_sb_ff[k-1];
            end
         end
      end

      ikin_sqrt_cell u_s_cell (
         .clock    (clock),
         .advance  (adv),
         .step_bit (ikin_pkg::SQ_TOP_BIT >> (2 * k)),
         .num_in   (s_num_i),
         .root_in  (s_root_i),
         .num_out  (s_num_w[k]),
         .root_out (s_root_w[k])
      );

      ikin_sqrt_cell u_t_cell (
         .clock    (clock),
         .advance  (adv),
         .step_bit (ikin_pkg::SQ_TOP_BIT >> (2 * k)),
         .num_in   (t_num_i),
         .root_in  (t_root_i),
         .num_out  (t_num_w[k]),
         .root_out (t_root_w[k])
      );
   end

   // ---------------------------------------------------------------- numerators
   ikin_pkg::sq_sb_type  sq_last;
   logic [31:0]          s_val, t_val;
   ikin_pkg::delta_type  px, py;
   logic signed [PW-1:0] p5_dxt_ff, p5_pxs_ff, p5_dyt_ff, p5_pys_ff;
   logic [31:0]          p5_t_ff;
   ikin_pkg::sq_sb_type  p5_sb_ff;
   logic signed [DVW-1:0] nx, ny;
   logic [DVW-1:0]       p6_xmag_ff, p6_ymag_ff;
   ikin_pkg::dv_sb_type  p6_sb_ff, p6_sb_in;

   always_comb begin
      sq_last = sq_sb_ff[SQ_N-1];
      s_val   = s_root_w[SQ_N-1][31:0];
      t_val   = t_root_w[SQ_N-1][31:0];
      // perpendicular on the chosen elbow side
      px = sq_last.side ? sq_last.dy : -sq_last.dy;
      py = sq_last.side ? -sq_last.dx : sq_last.dx;
      nx = DVW'(p5_dxt_ff) + DVW'(p5_pxs_ff) + DVW'(signed'({1'b0, p5_t_ff}));
      ny = DVW'(p5_dyt_ff) + DVW'(p5_pys_ff) + DVW'(signed'({1'b0, p5_t_ff}));
      p6_sb_in         = '0;
      p6_sb_in.oor     = p5_sb_ff.oor;
      p6_sb_in.ax      = p5_sb_ff.ax;
      p6_sb_in.ay      = p5_sb_ff.ay;
      p6_sb_in.dx      = p5_sb_ff.dx;
      p6_sb_in.dy      = p5_sb_ff.dy;
      p6_sb_in.xneg    = (nx < 0);
      p6_sb_in.yneg    = (ny < 0);
      p6_sb_in.divisor = {p5_t_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_dxt_ff  <= PW'(sq_last.dx) * PW'(signed'({1'b0, t_val}));
         p5_pxs_ff  <= PW'(px) * PW'(signed'({1'b0, s_val}));
         p5_dyt_ff  <= PW'(sq_last.dy) * PW'(signed'({1'b0, t_val}));
         p5_pys_ff  <= PW'(py) * PW'(signed'({1'b0, s_val}));
         p5_t_ff    <= t_val;
         p5_sb_ff   <= sq_last;
         p6_xmag_ff <= (nx < 0) ? DVW'(-nx) : DVW'(nx);
         p6_ymag_ff <= (ny < 0) ? DVW'(-ny) : DVW'(ny);
         p6_sb_ff   <= p6_sb_in;
      end
   end

   // ---------------------------------------------------------------- dividers
   logic [DVW-1:0]      x_rem_w [DV_N];
   logic [DV_N-1:0]     x_quo_w [DV_N];
   logic [DVW-1:0]      y_rem_w [DV_N];
   logic [DV_N-1:0]     y_quo_w [DV_N];
   ikin_pkg::dv_sb_type dv_sb_ff [DV_N];

   for (genvar k = 0; k < DV_N; k++) begin : g_dv
      logic [DVW-1:0]  x_rem_i, y_rem_i;
      logic [DV_N-1:0] x_quo_i, y_quo_i;
      logic [32:0]     div_i;
      if (k == 0) begin : g_head
         assign x_rem_i = p6_xmag_ff;
         assign y_rem_i = p6_ymag_ff;
         assign x_quo_i = '0;
         assign y_quo_i = '0;
         assign div_i   = p6_sb_ff.divisor;
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_sb_ff[k] <= p6_sb_ff;
            end
         end
      end else begin : g_link
         assign x_rem_i = x_rem_w[k-1];
         assign y_rem_i = y_rem_w[k-1];
         assign x_quo_i = x_quo_w[k-1];
         assign y_quo_i = y_quo_w[k-1];
         assign div_i   = dv_sb_ff[k-1].divisor;
         always_ff @(posedge clock) begin
            if (adv) begin
               dv_sb_ff[k] <= dv_sb_ff[k-1];
            end
         end
      end

      ikin_div_cell u_x_cell (
         .shift    (ikin_pkg::SHW'(DV_N - 1 - k)),
         .clock    (clock),
         .advance  (adv),
         .divisor  (div_i),
         .rem_in   (x_rem_i),
         .quot_in  (x_quo_i),
         .rem_out  (x_rem_w[k]),
         .quot_out (x_quo_w[k])
      );

      ikin_div_cell u_y_cell (
         .shift    (ikin_pkg::SHW'(DV_N - 1 - k)),
         .clock    (clock),
         .advance  (adv),
         .divisor  (div_i),
         .rem_in   (y_rem_i),
         .quot_in  (y_quo_i),
         .rem_out  (y_rem_w[k]),
         .quot_out (y_quo_w[k])
      );
   end

   // ---------------------------------------------------------------- joint
   ikin_pkg::dv_sb_type  dv_last;
   ikin_pkg::delta_type  qx, qy, fx_in, fy_in;
   ikin_pkg::delta_type  p7_fx_ff, p7_fy_ff, p7_dx_ff, p7_dy_ff;
   ikin_pkg::coord_type  p7_jx_ff, p7_jy_ff;
   logic                 p7_oor_ff;
   logic signed [21:0]   jx_full, jy_full;
   ikin_pkg::cr_init_type init1, init2;
   ikin_pkg::cr_sb_type  p8_sb_ff, p8_sb_in;
   ikin_pkg::cr_init_type p8_i1_ff, p8_i2_ff;

   always_comb begin
      dv_last = dv_sb_ff[DV_N-1];
      qx      = signed'({1'b0, x_quo_w[DV_N-1]});
      qy      = signed'({1'b0, y_quo_w[DV_N-1]});
      // floor of a negative quotient
      fx_in   = dv_last.xneg ? (-qx - 21'({20'b0, |x_rem_w[DV_N-1]})) : qx;
      fy_in   = dv_last.yneg ? (-qy - 21'({20'b0, |y_rem_w[DV_N-1]})) : qy;
      jx_full = 22'(dv_last.ax) + 22'(fx_in);
      jy_full = 22'(dv_last.ay) + 22'(fy_in);
      // angle vectors with screen y flipped upward
      init1   = cordic_prep(22'(p7_fx_ff), -22'(p7_fy_ff));
      init2   = cordic_prep(22'(p7_dx_ff) - 22'(p7_fx_ff), 22'(p7_fy_ff) - 22'(p7_dy_ff));
      p8_sb_in       = '0;
      p8_sb_in.oor   = p7_oor_ff;
      p8_sb_in.jx    = p7_jx_ff;
      p8_sb_in.jy    = p7_jy_ff;
      p8_sb_in.fix1  = init1.fix;
      p8_sb_in.fixv1 = init1.fixv;
      p8_sb_in.fix2  = init2.fix;
      p8_sb_in.fixv2 = init2.fixv;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p7_fx_ff  <= fx_in;
         p7_fy_ff  <= fy_in;
         p7_dx_ff  <= dv_last.dx;
         p7_dy_ff  <= dv_last.dy;
         p7_jx_ff  <= sat20(jx_full);
         p7_jy_ff  <= sat20(jy_full);
         p7_oor_ff <= dv_last.oor;
         p8_i1_ff  <= init1;
         p8_i2_ff  <= init2;
         p8_sb_ff  <= p8_sb_in;
      end
   end

   // ---------------------------------------------------------------- angles
   logic signed [CW-1:0] a_x_w [CR_N];
   logic signed [CW-1:0] a_y_w [CR_N];
   logic signed [ZW-1:0] a_z_w [CR_N];
   logic signed [CW-1:0] b_x_w [CR_N];
   logic signed [CW-1:0] b_y_w [CR_N];
   logic signed [ZW-1:0] b_z_w [CR_N];
   ikin_pkg::cr_sb_type  cr_sb_ff [CR_N];

   for (genvar k = 0; k < CR_N; k++) begin : g_cr
      logic signed [CW-1:0] a_x_i, a_y_i, b_x_i, b_y_i;
      logic signed [ZW-1:0] a_z_i, b_z_i;
      if (k == 0) begin : g_head
         assign a_x_i = p8_i1_ff.x;
         assign a_y_i = p8_i1_ff.y;
         assign a_z_i = p8_i1_ff.z;
         assign b_x_i = p8_i2_ff.x;
         assign b_y_i = p8_i2_ff.y;
         assign b_z_i = p8_i2_ff.z;
         always_ff @(posedge clock) begin
            if (adv) begin
               cr_sb_ff[k] <= p8_sb_ff;
            end
         end
      end else begin : g_link
         assign a_x_i = a_x_w[k-1];
         assign a_y_i = a_y_w[k-1];
         assign a_z_i = a_z_w[k-1];
         assign b_x_i = b_x_w[k-1];
         assign b_y_i = b_y_w[k-1];
         assign b_z_i = b_z_w[k-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               cr_sb_ff[k] <= cr_sb_ff[k-1];
            end
         end
      end

      ikin_cordic_cell u_a_cell (
         .clock   (clock),
         .advance (adv),
         .shift   (ikin_pkg::SHW'(k)),
         .atan    (ikin_pkg::ATAN_TAB[k]),
         .x_in    (a_x_i),
         .y_in    (a_y_i),
         .z_in    (a_z_i),
         .x_out   (a_x_w[k]),
         .y_out   (a_y_w[k]),
         .z_out   (a_z_w[k])
      );

      ikin_cordic_cell u_b_cell (
         .clock   (clock),
         .advance (adv),
         .shift   (ikin_pkg::SHW'(k)),
         .atan    (ikin_pkg::ATAN_TAB[k]),
         .x_in    (b_x_i),
         .y_in    (b_y_i),
         .z_in    (b_z_i),
         .x_out   (b_x_w[k]),
         .y_out   (b_y_w[k]),
         .z_out   (b_z_w[k])
      );
   end

   // ---------------------------------------------------------------- result word
   ikin_pkg::cr_sb_type    cr_last;
   ikin_pkg::rsp_word_type p9_word_in, p9_word_ff;

   always_comb begin
      cr_last    = cr_sb_ff[CR_N-1];
      p9_word_in = '0;
      p9_word_in.out_of_reach = cr_last.oor;
      if (!cr_last.oor) begin
         p9_word_in.joint_x      = cr_last.jx;
         p9_word_in.joint_y      = cr_last.jy;
         p9_word_in.first_angle  = angle_done(a_z_w[CR_N-1], cr_last.fix1, cr_last.fixv1);
         p9_word_in.second_angle = angle_done(b_z_w[CR_N-1], cr_last.fix2, cr_last.fixv2);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p9_word_ff <= p9_word_in;
      end
   end

   // ---------------------------------------------------------------- output and skid
   assign inc_v = vld_ff[LAT-1] && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_chan.ready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= inc_v;
         end
      end else if (inc_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_chan.ready) begin
         out_word_ff <= skid_v_ff ? skid_word_ff : p9_word_ff;
      end else if (inc_v) begin
         skid_word_ff <= p9_word_ff;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.joint_x      = out_word_ff.joint_x;
   assign rsp_chan.joint_y      = out_word_ff.joint_y;
   assign rsp_chan.first_angle  = out_word_ff.first_angle;
   assign rsp_chan.second_angle = out_word_ff.second_angle;
   assign rsp_chan.out_of_reach = out_word_ff.out_of_reach;

endmodule

`default_nettype wire

// File: rtl/core/ikin_checker.sv
// Port-level checks of the result channel, bound to the top level.
// Depends on ikin_pkg and the assertion macro header.
`default_nettype none
`include "two_link_arm_inverse_kinematics_macros.svh"

module ikin_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire ikin_pkg::coord_type joint_x,
   input wire ikin_pkg::coord_type joint_y,
   input wire ikin_pkg::angle_type first_angle,
   input wire ikin_pkg::angle_type second_angle,
   input wire logic                out_of_reach
);

   // a waiting word stays offered and unchanged
   `IKIN_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp word dropped")
   `IKIN_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(joint_x) && $stable(joint_y) && $stable(first_angle) && $stable(second_angle) && $stable(out_of_reach), "rsp word changed while stalled")

   // unreachable target gives an all-zero word
   `IKIN_ASSERT(a_oor_zero, clock, reset, rsp_valid && out_of_reach |-> joint_x == 0 && joint_y == 0 && first_angle == 0 && second_angle == 0, "out of reach word not zero")

   // angles stay inside one turn
   `IKIN_ASSERT_NEVER(a_angle_range, clock, reset, rsp_valid && (first_angle >= ikin_pkg::FULL_TURN || second_angle >= ikin_pkg::FULL_TURN), "angle beyond one turn")

endmodule

bind two_link_arm_inverse_kinematics ikin_checker u_ikin_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .joint_x      (rsp_chan.joint_x),
   .joint_y      (rsp_chan.joint_y),
   .first_angle  (rsp_chan.first_angle),
   .second_angle (rsp_chan.second_angle),
   .out_of_reach (rsp_chan.out_of_reach)
);

`default_nettype wire
